[src/ft_sensor_gravity_compensated_wrench_top_macros.svh]
// assertion macros shared by the checker
`ifndef FT_SENSOR_GRAVITY_COMPENSATED_WRENCH_TOP_MACROS_SVH
`define FT_SENSOR_GRAVITY_COMPENSATED_WRENCH_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define FTG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define FTG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[src/ftg_pkg.sv]
// package: payload types, constants and fixed-point helpers
`timescale 1ns / 1ps
package ftg_pkg;
    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned CFG_DATA_W = 54;
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic signed [17:0] LEVER_Z_Q16 = -18'sd5767;

    localparam logic [CFG_IDX_W-1:0] REG_SFE0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SFE1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SFE2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd7;

    typedef struct packed {
        logic [53:0]        pose_rot_row0;
        logic [53:0]        pose_rot_row1;
        logic [53:0]        pose_rot_row2;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] torque_x;
        logic signed [31:0] torque_y;
        logic signed [31:0] torque_z;
        logic               bias_done;
        logic               bias_fault;
        logic               link_fault;
    } t_in;

    typedef struct packed {
        logic signed [31:0] base_force_x;
        logic signed [31:0] base_force_y;
        logic signed [31:0] base_force_z;
        logic signed [31:0] base_torque_x;
        logic signed [31:0] base_torque_y;
        logic signed [31:0] base_torque_z;
        logic               wrench_valid;
    } t_out;

    // q1.16 entry of a packed row, column 0 at the top
    function automatic logic signed [17:0] entry_of(input logic [53:0] row, input int col);
        logic signed [17:0] e;
        case (col)
            0: e = row[53:36];
            1: e = row[35:18];
            default: e = row[17:0];
        endcase
        return e;
    endfunction

    // q.32 to q.16 round half up, 64-bit input
    function automatic logic signed [47:0] rnd64(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = x + 64'sd32768;
        return y[63:16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [31:0] r;
        if (x > 48'sh7FFFFFFF) r = 32'sh7FFFFFFF;
        else if (x < -48'sh80000000) r = -32'sh80000000;
        else r = x[31:0];
        return r;
    endfunction
endpackage

[src/ft_sensor_gravity_compensated_wrench_top.sv]
// top level: gravity-compensated wrench pipeline
// throughput: one request per cycle; stage 1 rotation product, stage 2 gravity
// terms, stage 3 base-frame force and rotated torque, stage 4 lever moment and torque saturation
// a stall holds every stage; ready falls only when the output register is full and not taken
// reset (sync, active low) clears valid bits and restores register defaults
`timescale 1ns / 1ps
module ft_sensor_gravity_compensated_wrench_top
    import ftg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in                   i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out                  o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    // configuration registers
    logic [53:0] r_sfe [3];
    logic [53:0] r_init [3];
    logic [30:0] r_weight;
    logic [30:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sfe[0] <= 54'd65536 << 36;
            r_sfe[1] <= 54'd65536 << 18;
            r_sfe[2] <= 54'd65536;
            r_init[0] <= 54'd65536 << 36;
            r_init[1] <= 54'd65536 << 18;
            r_init[2] <= 54'd65536;
            r_weight <= 31'd185158;
            r_gain <= 31'd2949;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SFE0:   r_sfe[0] <= i_cfg_data;
                REG_SFE1:   r_sfe[1] <= i_cfg_data;
                REG_SFE2:   r_sfe[2] <= i_cfg_data;
                REG_INIT0:  r_init[0] <= i_cfg_data;
                REG_INIT1:  r_init[1] <= i_cfg_data;
                REG_INIT2:  r_init[2] <= i_cfg_data;
                REG_WEIGHT: r_weight <= i_cfg_data[30:0];
                REG_GAIN:   r_gain <= i_cfg_data[30:0];
                default:    ;
            endcase
        end
    end

    // whole pipe advances together; holds when output full and not taken
    logic adv;
    logic [3:0] r_v;
    assign adv = !r_v[3] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // stage 1: rotation
    logic [53:0] p_rows [3];
    logic signed [20:0] rot [3][3];
    assign p_rows[0] = i_data.pose_rot_row0;
    assign p_rows[1] = i_data.pose_rot_row1;
    assign p_rows[2] = i_data.pose_rot_row2;

    ftg_rot u_rot (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_s   (r_sfe),
        .i_p   (p_rows),
        .o_r   (rot)
    );

    logic signed [31:0] r_f1 [3];
    logic signed [31:0] r_t1 [3];
    logic               r_ok1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f1[0] <= i_data.force_x;
            r_f1[1] <= i_data.force_y;
            r_f1[2] <= i_data.force_z;
            r_t1[0] <= i_data.torque_x;
            r_t1[1] <= i_data.torque_y;
            r_t1[2] <= i_data.torque_z;
            r_ok1 <= i_data.bias_done && !i_data.bias_fault && !i_data.link_fault;
        end
    end

    // stage 2: gravity-compensated sensor wrench
    logic signed [47:0] n_fs [3];
    logic signed [47:0] n_ts [3];
    logic signed [47:0] r_fs [3];
    logic signed [47:0] r_ts [3];
    logic signed [20:0] r_rot2 [3][3];
    logic signed [17:0] n_ro [3];
    logic signed [17:0] r_ro [3];
    logic               r_ok2;
    logic signed [63:0] w_s, g_s;
    assign w_s = {33'd0, r_weight};
    assign g_s = {33'd0, r_gain};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_fs[i] = 48'(r_f1[i]) + rnd64(w_s * (64'(rot[i][2]) - 64'(entry_of(r_init[i], 2))));
            n_ro[i] = 18'(rnd64(64'(LEVER_Z_Q16) * 64'(rot[2][i])));
        end
        n_ts[0] = 48'(r_t1[0]) + rnd64(g_s * (64'(entry_of(r_init[1], 2)) - 64'(rot[1][2])));
        n_ts[1] = 48'(r_t1[1]) + rnd64(g_s * (64'(rot[0][2]) - 64'(entry_of(r_init[0], 2))));
        n_ts[2] = 48'(r_t1[2]);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fs <= n_fs;
            r_ts <= n_ts;
            r_ro <= n_ro;
            r_rot2 <= rot;
            r_ok2 <= r_ok1;
        end
    end

    // stage 3: base-frame force and rotated torque sum
    logic signed [31:0] n_f [3];
    logic signed [63:0] n_tacc [3];
    logic signed [31:0] r_f [3];
    logic signed [63:0] r_tacc [3];
    logic signed [17:0] r_ro3 [3];
    logic               r_ok3;
    logic signed [63:0] facc, tacc;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            facc = '0;
            tacc = '0;
            for (int k = 0; k < 3; k++) begin
                facc = facc + 64'(r_rot2[k][i]) * 64'(r_fs[k]);
                tacc = tacc + 64'(r_rot2[k][i]) * 64'(r_ts[k]);
            end
            n_f[i] = sat32(rnd64(facc));
            n_tacc[i] = tacc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f <= n_f;
            r_tacc <= n_tacc;
            r_ro3 <= r_ro;
            r_ok3 <= r_ok2;
        end
    end

    // stage 4: lever moment, saturation, validity gate
    t_out n_out, r_out;
    logic signed [31:0] n_t [3];
    logic signed [63:0] lacc;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lacc = r_tacc[i]
                 + 64'(r_ro3[(i + 1) % 3]) * 64'(r_f[(i + 2) % 3])
                 - 64'(r_ro3[(i + 2) % 3]) * 64'(r_f[(i + 1) % 3]);
            n_t[i] = sat32(rnd64(lacc));
        end
        n_out = '0;
        if (r_ok3) begin
            n_out.base_force_x = r_f[0];
            n_out.base_force_y = r_f[1];
            n_out.base_force_z = r_f[2];
            n_out.base_torque_x = n_t[0];
            n_out.base_torque_y = n_t[1];
            n_out.base_torque_z = n_t[2];
            n_out.wrench_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;
endmodule

[src/ftg_rot.sv]
// rotation stage: r = s * p^t with rounding, one registered stage
`timescale 1ns / 1ps
module ftg_rot
    import ftg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [53:0] i_s [3],
    input  logic [53:0] i_p [3],
    output logic signed [20:0] o_r [3][3]
);
    logic signed [20:0] n_r [3][3];
    logic signed [20:0] r_r [3][3];
    logic signed [63:0] acc;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = '0;
                for (int k = 0; k < 3; k++) begin
                    acc = acc + 64'(entry_of(i_s[i], k)) * 64'(entry_of(i_p[j], k));
                end
                n_r[i][j] = 21'(rnd64(acc));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r <= n_r;
        end
    end

    assign o_r = r_r;
endmodule

[src/ftg_checker.sv]
// port-level checker for the wrench pipeline, bound to the top level
`timescale 1ns / 1ps
`include "ft_sensor_gravity_compensated_wrench_top_macros.svh"
module ftg_checker
    import ftg_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);
    `FTG_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !o_valid, o_ready)
    `FTG_ASSERT_IMP(a_zero_when_invalid, i_clk, i_rst_n, o_valid && !o_data.wrench_valid, o_data == '0)
    `FTG_ASSERT_NXT(a_out_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
endmodule

bind ft_sensor_gravity_compensated_wrench_top ftg_checker u_ftg_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
